>>> rtl/sssp_pkg.sv
package sssp_pkg;

	typedef enum logic [2:0] {
		REG_VOLUME_MODE,
		REG_INNER_RADIUS,
		REG_OUTER_RADIUS,
		REG_CENTER_XYZ,
		REG_THETA_START,
		REG_THETA_SPAN,
		REG_Z_LOW,
		REG_Z_HIGH
	} reg_idx_t;

	localparam int                 ROOT_STAGES = 17;
	localparam logic        [14:0] ONE_Q14     = 15'd16384;
	localparam logic signed [15:0] Z_ONE       = 16'sd16384;
	localparam logic        [16:0] FULL_TURN   = 17'd65536;
	localparam logic        [28:0] ONE_SQ      = 29'h1000_0000;
	localparam logic        [14:0] SIN_A       = 15'd25736;
	localparam logic        [13:0] SIN_B       = 14'd10512;
	localparam logic        [10:0] SIN_C       = 11'd1160;

	// configuration after swap and clamp fix-ups
	typedef struct packed {
		logic               mode;
		logic        [15:0] ri;
		logic        [15:0] ro;
		logic signed [15:0] zl;
		logic signed [15:0] zh;
		logic        [15:0] tstart;
		logic        [16:0] span;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic signed [15:0] cz;
	} cfg_t;

	// per-item geometry handed from the front stages to the roots and beyond
	typedef struct packed {
		logic [15:0] r_surf;
		logic [47:0] cube_v;
		logic [28:0] sq_v;
		logic [14:0] sin_mag;
		logic        sin_neg;
		logic [14:0] cos_mag;
		logic        cos_neg;
		logic [14:0] za;
		logic        zneg;
	} geo_t;

endpackage

>>> rtl/sssp_front.sv
module sssp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [15:0]         rand_radius,
	input  logic [15:0]         rand_theta,
	input  logic [15:0]         rand_z,
	input  sssp_pkg::cfg_t      cfg,
	output logic                out_valid,
	output sssp_pkg::geo_t      out_geo
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [15:0] zd;
	logic [47:0] d3;
	logic [14:0] qa, qb;
	logic [14:0] t2a, t2b;
	logic [13:0] i1a, i1b;
	logic [14:0] i2a, i2b;

	logic [31:0] ri2_s1, ro2_s1, zp_s1;
	logic [32:0] tp_s1;
	logic [15:0] ur_s1;

	logic [47:0]        ri3_s2, ro3_s2;
	logic [31:0]        a_s2;
	logic [32:0]        sum_s2;
	logic signed [16:0] zn_s2;
	logic [15:0]        theta_s2;
	logic [15:0]        ur_s2;

	logic [39:0] ahi_s3, alo_s3;
	logic [47:0] i3_s3;
	logic [48:0] ps_s3;
	logic [31:0] a_s3;
	logic [32:0] sum_s3;
	logic [14:0] za_s3;
	logic        zneg_s3;
	logic [1:0]  quad_s3;
	logic [14:0] ta_s3, tb_s3;
	logic [28:0] tsa_s3, tsb_s3;

	logic [47:0] cube_v_s4;
	logic        pick_s4;
	logic [28:0] sq_v_s4;
	logic [25:0] m1a_s4, m1b_s4;
	logic [14:0] t2a_s4, t2b_s4, ta_s4, tb_s4, za_s4;
	logic        zneg_s4;
	logic [1:0]  quad_s4;

	logic [47:0] cube_v_s5;
	logic        pick_s5;
	logic [28:0] sq_v_s5;
	logic [28:0] m2a_s5, m2b_s5;
	logic [14:0] ta_s5, tb_s5, za_s5;
	logic        zneg_s5;
	logic [1:0]  quad_s5;

	logic [47:0] cube_v_s6;
	logic        pick_s6;
	logic [28:0] sq_v_s6;
	logic [29:0] m3a_s6, m3b_s6;
	logic [14:0] za_s6;
	logic        zneg_s6;
	logic [1:0]  quad_s6;

	logic [14:0] sa, sb;

	assign zd  = 16'(cfg.zh - cfg.zl);
	assign d3  = ro3_s2 - ri3_s2;
	assign qa  = {1'b0, theta_s2[13:0]};
	assign qb  = sssp_pkg::ONE_Q14 - {1'b0, theta_s2[13:0]};
	assign t2a = tsa_s3[28:14];
	assign t2b = tsb_s3[28:14];
	assign i1a = sssp_pkg::SIN_B - 14'(m1a_s4 >> 14);
	assign i1b = sssp_pkg::SIN_B - 14'(m1b_s4 >> 14);
	assign i2a = sssp_pkg::SIN_A - 15'(m2a_s5 >> 14);
	assign i2b = sssp_pkg::SIN_A - 15'(m2b_s5 >> 14);
	assign sa  = 15'(m3a_s6 >> 14);
	assign sb  = 15'(m3b_s6 >> 14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// squares of the radii, band and azimuth scaling
			ri2_s1 <= 32'(cfg.ri) * 32'(cfg.ri);
			ro2_s1 <= 32'(cfg.ro) * 32'(cfg.ro);
			zp_s1  <= 32'(rand_z) * 32'(zd);
			tp_s1  <= 33'(rand_theta) * 33'(cfg.span);
			ur_s1  <= rand_radius;

			// cubes, z and azimuth
			ri3_s2   <= 48'(ri2_s1) * 48'(cfg.ri);
			ro3_s2   <= 48'(ro2_s1) * 48'(cfg.ro);
			a_s2     <= ri2_s1;
			sum_s2   <= 33'(ri2_s1) + 33'(ro2_s1);
			zn_s2    <= 17'(cfg.zl) + $signed({1'b0, zp_s1[31:16]});
			theta_s2 <= cfg.tstart + tp_s1[31:16];
			ur_s2    <= ur_s1;

			// radius fraction products, z magnitude, quarter-wave squares
			ahi_s3  <= 40'(ur_s2) * 40'(d3[47:24]);
			alo_s3  <= 40'(ur_s2) * 40'(d3[23:0]);
			i3_s3   <= ri3_s2;
			ps_s3   <= 49'(ur_s2) * 49'(sum_s2);
			a_s3    <= a_s2;
			sum_s3  <= sum_s2;
			za_s3   <= zn_s2[16] ? 15'(-zn_s2) : 15'(zn_s2);
			zneg_s3 <= zn_s2[16];
			quad_s3 <= theta_s2[15:14];
			ta_s3   <= qa;
			tb_s3   <= qb;
			tsa_s3  <= 29'(qa) * 29'(qa);
			tsb_s3  <= 29'(qb) * 29'(qb);

			// cube target, surface pick, square root target
			cube_v_s4 <= i3_s3 + {ahi_s3, 8'b0} + 48'(alo_s3[39:16]);
			pick_s4   <= (sum_s3 != 33'd0) &&
				((65'({ps_s3, 15'b0}) + 65'(sum_s3)) <= 65'({a_s3, 31'b0}));
			sq_v_s4   <= sssp_pkg::ONE_SQ - 29'(za_s3) * 29'(za_s3);
			m1a_s4    <= 26'(t2a) * 26'(sssp_pkg::SIN_C);
			m1b_s4    <= 26'(t2b) * 26'(sssp_pkg::SIN_C);
			t2a_s4    <= t2a;
			t2b_s4    <= t2b;
			ta_s4     <= ta_s3;
			tb_s4     <= tb_s3;
			za_s4     <= za_s3;
			zneg_s4   <= zneg_s3;
			quad_s4   <= quad_s3;

			cube_v_s5 <= cube_v_s4;
			pick_s5   <= pick_s4;
			sq_v_s5   <= sq_v_s4;
			m2a_s5    <= 29'(t2a_s4) * 29'(i1a);
			m2b_s5    <= 29'(t2b_s4) * 29'(i1b);
			ta_s5     <= ta_s4;
			tb_s5     <= tb_s4;
			za_s5     <= za_s4;
			zneg_s5   <= zneg_s4;
			quad_s5   <= quad_s4;

			cube_v_s6 <= cube_v_s5;
			pick_s6   <= pick_s5;
			sq_v_s6   <= sq_v_s5;
			m3a_s6    <= 30'(ta_s5) * 30'(i2a);
			m3b_s6    <= 30'(tb_s5) * 30'(i2b);
			za_s6     <= za_s5;
			zneg_s6   <= zneg_s5;
			quad_s6   <= quad_s5;
		end
	end

	always_comb begin
		out_geo.r_surf = pick_s6 ? cfg.ri : cfg.ro;
		out_geo.cube_v = cube_v_s6;
		out_geo.sq_v   = sq_v_s6;
		out_geo.za     = za_s6;
		out_geo.zneg   = zneg_s6;
		case (quad_s6)
			2'd0: begin
				out_geo.sin_mag = sa;
				out_geo.sin_neg = 1'b0;
				out_geo.cos_mag = sb;
				out_geo.cos_neg = 1'b0;
			end
			2'd1: begin
				out_geo.sin_mag = sb;
				out_geo.sin_neg = 1'b0;
				out_geo.cos_mag = sa;
				out_geo.cos_neg = 1'b1;
			end
			2'd2: begin
				out_geo.sin_mag = sa;
				out_geo.sin_neg = 1'b1;
				out_geo.cos_mag = sb;
				out_geo.cos_neg = 1'b1;
			end
			default: begin
				out_geo.sin_mag = sb;
				out_geo.sin_neg = 1'b1;
				out_geo.cos_mag = sa;
				out_geo.cos_neg = 1'b0;
			end
		endcase
	end

	assign out_valid = v_s6;

endmodule

>>> rtl/sssp_root.sv
module sssp_root (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  sssp_pkg::geo_t in_geo,
	output logic           out_valid,
	output sssp_pkg::geo_t out_geo,
	output logic [15:0]    r_cube,
	output logic [14:0]    s_root
);

	localparam int N = sssp_pkg::ROOT_STAGES;

	logic                 vld_s  [1:N];
	sssp_pkg::geo_t       geo_s  [1:N];
	logic [16:0]          cr_s   [1:N];
	logic [33:0]          cr2_s  [1:N];
	logic [47:0]          cr3_s  [1:N];
	logic [16:0]          sr_s   [1:N];
	logic [33:0]          sr2_s  [1:N];

	// one result bit of each root per stage, msb first
	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int B = N - 1 - k;

		logic           v_in;
		sssp_pkg::geo_t g_in;
		logic [16:0]    cr_in, sr_in;
		logic [33:0]    cr2_in, sr2_in;
		logic [47:0]    cr3_in;
		logic [51:0]    c3;
		logic [33:0]    c2_cube;
		logic [34:0]    c2_sq;
		logic           ok_c, ok_s;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign g_in   = in_geo;
			assign cr_in  = '0;
			assign cr2_in = '0;
			assign cr3_in = '0;
			assign sr_in  = '0;
			assign sr2_in = '0;
		end else begin : g_next
			assign v_in   = vld_s[k];
			assign g_in   = geo_s[k];
			assign cr_in  = cr_s[k];
			assign cr2_in = cr2_s[k];
			assign cr3_in = cr3_s[k];
			assign sr_in  = sr_s[k];
			assign sr2_in = sr2_s[k];
		end

		// (r + 2^b)^3 and (r + 2^b)^2 from the running powers
		assign c3 = 52'(cr3_in) + (52'(cr2_in) << B) + (52'(cr2_in) << (B + 1)) +
			(52'(cr_in) << (2 * B)) + (52'(cr_in) << (2 * B + 1)) + (52'(1) << (3 * B));
		assign c2_cube = cr2_in + (34'(cr_in) << (B + 1)) + (34'(1) << (2 * B));
		assign c2_sq   = 35'(sr2_in) + (35'(sr_in) << (B + 1)) + (35'(1) << (2 * B));
		assign ok_c    = c3 <= 52'(g_in.cube_v);
		assign ok_s    = c2_sq <= 35'(g_in.sq_v);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k + 1] <= 1'b0;
			end else if (en) begin
				vld_s[k + 1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				geo_s[k + 1] <= g_in;
				cr_s[k + 1]  <= ok_c ? (cr_in | (17'(1) << B)) : cr_in;
				cr2_s[k + 1] <= ok_c ? c2_cube : cr2_in;
				cr3_s[k + 1] <= ok_c ? c3[47:0] : cr3_in;
				sr_s[k + 1]  <= ok_s ? (sr_in | (17'(1) << B)) : sr_in;
				sr2_s[k + 1] <= ok_s ? c2_sq[33:0] : sr2_in;
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_geo   = geo_s[N];
	assign r_cube    = cr_s[N][15:0];
	assign s_root    = sr_s[N][14:0];

endmodule

>>> rtl/sssp_back.sv
module sssp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  sssp_pkg::geo_t     geo,
	input  logic [15:0]        r_cube,
	input  logic [14:0]        s_root,
	input  sssp_pkg::cfg_t     cfg,
	output logic               out_valid,
	output logic [15:0]        point_x,
	output logic [15:0]        point_y,
	output logic [15:0]        point_z,
	output logic               clipped
);

	function automatic logic [16:0] sat16(input logic signed [20:0] v);
		logic [16:0] res;
		if (v > 21'sd32767) begin
			res = {1'b1, 16'h7fff};
		end else if (v < -21'sd32768) begin
			res = {1'b1, 16'h8000};
		end else begin
			res = {1'b0, v[15:0]};
		end
		return res;
	endfunction

	logic [15:0] radius;

	logic        v_s1, v_s2, v_s3;
	logic [30:0] rs_s1, rz_s1;
	logic [14:0] cmag_s1, smag_s1;
	logic        cneg_s1, sneg_s1, zneg_s1;
	logic [45:0] px_s2, py_s2;
	logic [30:0] rz_s2;
	logic        cneg_s2, sneg_s2, zneg_s2;

	logic [18:0]        ox, oy;
	logic [17:0]        oz;
	logic signed [20:0] sx, sy, sz;
	logic [16:0]        qx, qy, qz;

	assign radius = cfg.mode ? r_cube : geo.r_surf;

	// round half away from zero on the magnitudes, then apply the sign
	assign ox = 19'((47'(px_s2) + (47'(1) << 27)) >> 28);
	assign oy = 19'((47'(py_s2) + (47'(1) << 27)) >> 28);
	assign oz = 18'((32'(rz_s2) + (32'(1) << 13)) >> 14);
	assign sx = 21'(cfg.cx) + (cneg_s2 ? -$signed(21'(ox)) : $signed(21'(ox)));
	assign sy = 21'(cfg.cy) + (sneg_s2 ? -$signed(21'(oy)) : $signed(21'(oy)));
	assign sz = 21'(cfg.cz) + (zneg_s2 ? -$signed(21'(oz)) : $signed(21'(oz)));
	assign qx = sat16(sx);
	assign qy = sat16(sy);
	assign qz = sat16(sz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rs_s1   <= 31'(radius) * 31'(s_root);
			rz_s1   <= 31'(radius) * 31'(geo.za);
			cmag_s1 <= geo.cos_mag;
			smag_s1 <= geo.sin_mag;
			cneg_s1 <= geo.cos_neg;
			sneg_s1 <= geo.sin_neg;
			zneg_s1 <= geo.zneg;

			px_s2   <= 46'(rs_s1) * 46'(cmag_s1);
			py_s2   <= 46'(rs_s1) * 46'(smag_s1);
			rz_s2   <= rz_s1;
			cneg_s2 <= cneg_s1;
			sneg_s2 <= sneg_s1;
			zneg_s2 <= zneg_s1;

			point_x <= qx[15:0];
			point_y <= qy[15:0];
			point_z <= qz[15:0];
			clipped <= qx[16] | qy[16] | qz[16];
		end
	end

	assign out_valid = v_s3;

endmodule

>>> rtl/spherical_shell_point_sampler.sv
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       tdata: rand_radius, rand_theta, rand_z
// m_*       out  m_tvalid / m_tready       tdata: point_x, point_y, point_z; tuser: clipped
// cfg_*     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one request per cycle while the output is not held; 6 front stages, 17 root stages
// doing one bit of the cube root and the square root each, 3 output stages
// reset clears the valid bits and loads the register defaults; no clearing pass
// all stages hold together while m_tvalid is high and m_tready is low
module spherical_shell_point_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // rand_radius, rand_theta, rand_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // point_x, point_y, point_z
	output logic [0:0]  m_tuser,   // clipped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	logic               mode_q;
	logic [15:0]        inner_q, outer_q, tstart_q;
	logic [47:0]        center_q;
	logic [16:0]        tspan_q;
	logic signed [15:0] zlow_q, zhigh_q;

	logic               en;
	logic signed [15:0] zl_c, zh_c;
	sssp_pkg::cfg_t     cfg;

	logic           f_valid, r_valid;
	sssp_pkg::geo_t f_geo, r_geo;
	logic [15:0]    r_cube;
	logic [14:0]    s_root;
	logic [15:0]    px, py, pz;
	logic           clip;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b1;
			inner_q  <= 16'd0;
			outer_q  <= 16'd256;
			center_q <= 48'd0;
			tstart_q <= 16'd0;
			tspan_q  <= sssp_pkg::FULL_TURN;
			zlow_q   <= -sssp_pkg::Z_ONE;
			zhigh_q  <= sssp_pkg::Z_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (sssp_pkg::reg_idx_t'(cfg_index))
				sssp_pkg::REG_VOLUME_MODE:  mode_q   <= cfg_data[0];
				sssp_pkg::REG_INNER_RADIUS: inner_q  <= cfg_data[15:0];
				sssp_pkg::REG_OUTER_RADIUS: outer_q  <= cfg_data[15:0];
				sssp_pkg::REG_CENTER_XYZ:   center_q <= cfg_data;
				sssp_pkg::REG_THETA_START:  tstart_q <= cfg_data[15:0];
				sssp_pkg::REG_THETA_SPAN:   tspan_q  <= cfg_data[16:0];
				sssp_pkg::REG_Z_LOW:        zlow_q   <= $signed(cfg_data[15:0]);
				sssp_pkg::REG_Z_HIGH:       zhigh_q  <= $signed(cfg_data[15:0]);
			endcase
		end
	end

	// fix-ups applied at use
	always_comb begin
		zl_c = (zlow_q < -sssp_pkg::Z_ONE) ? -sssp_pkg::Z_ONE :
			((zlow_q > sssp_pkg::Z_ONE) ? sssp_pkg::Z_ONE : zlow_q);
		zh_c = (zhigh_q < -sssp_pkg::Z_ONE) ? -sssp_pkg::Z_ONE :
			((zhigh_q > sssp_pkg::Z_ONE) ? sssp_pkg::Z_ONE : zhigh_q);
		cfg.mode   = mode_q;
		cfg.ri     = (inner_q > outer_q) ? outer_q : inner_q;
		cfg.ro     = (inner_q > outer_q) ? inner_q : outer_q;
		cfg.zl     = (zl_c > zh_c) ? zh_c : zl_c;
		cfg.zh     = (zl_c > zh_c) ? zl_c : zh_c;
		cfg.tstart = tstart_q;
		cfg.span   = (tspan_q > sssp_pkg::FULL_TURN) ? sssp_pkg::FULL_TURN : tspan_q;
		cfg.cx     = $signed(center_q[15:0]);
		cfg.cy     = $signed(center_q[31:16]);
		cfg.cz     = $signed(center_q[47:32]);
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	sssp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (s_tvalid),
		.rand_radius (s_tdata[15:0]),
		.rand_theta  (s_tdata[31:16]),
		.rand_z      (s_tdata[47:32]),
		.cfg         (cfg),
		.out_valid   (f_valid),
		.out_geo     (f_geo)
	);

	sssp_root u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_geo    (f_geo),
		.out_valid (r_valid),
		.out_geo   (r_geo),
		.r_cube    (r_cube),
		.s_root    (s_root)
	);

	sssp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_valid),
		.geo       (r_geo),
		.r_cube    (r_cube),
		.s_root    (s_root),
		.cfg       (cfg),
		.out_valid (m_tvalid),
		.point_x   (px),
		.point_y   (py),
		.point_z   (pz),
		.clipped   (clip)
	);

	assign m_tdata = {pz, py, px};
	assign m_tuser = clip;

	a_clip_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(px == 16'h7fff) || (px == 16'h8000) || (py == 16'h7fff) ||
			(py == 16'h8000) || (pz == 16'h7fff) || (pz == 16'h8000))
		else $error("clip flag without a saturated coordinate");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output held");

	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

endmodule
